FILE: rtl/core/ftar_pkg.sv
// Shared constants and control types for the fan tachometer auto-range block.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package ftar_pkg;

   // Field widths
   localparam int FAN_W   = 3;
   localparam int COUNT_W = 8;
   localparam int EXP_W   = 3;
   localparam int SPEED_W = 21;
   localparam int THR_W   = 8;

   // Divider geometry: divisor is count shifted by up to seven places
   localparam int DIV_W   = COUNT_W + 7;
   localparam int REM_W   = DIV_W + 1;
   localparam int QUO_W   = SPEED_W;
   localparam int STEP_W  = $clog2(QUO_W);

   // Constants of the speed formula and auto-ranging
   localparam logic [SPEED_W-1:0] RPM_NUMERATOR = 21'd1350000;
   localparam logic [COUNT_W-1:0] STALL_COUNT   = 8'hFF;
   localparam logic [EXP_W-1:0]   MAX_EXPONENT  = 3'd7;

   // Configuration registers
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWER_THRESHOLD = 1'd1;
   localparam logic [THR_W-1:0] UPPER_THRESHOLD_RESET = 8'd192;
   localparam logic [THR_W-1:0] LOWER_THRESHOLD_RESET = 8'd96;

   localparam int NUM_FANS_DEFAULT = 8;

   // Controller to datapath
   typedef struct packed {
      logic accept;   // capture the request transaction, update exponent
      logic init;     // load the divider
      logic step;     // one quotient bit
      logic publish;  // move the result into the output register
   } ftar_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_valid;
      logic step_last;
      logic out_free;
   } ftar_status_type;

endpackage

FILE: rtl/core/ftar_if.sv
// Request and response channel interfaces for the fan tachometer block.
// Depends on ftar_pkg for field widths.
`timescale 1ns / 1ps

interface ftar_req_if import ftar_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FAN_W-1:0]   fan_index;
   logic [COUNT_W-1:0] tach_count;

   modport source (output valid, output fan_index, output tach_count, input ready);
   modport sink   (input valid, input fan_index, input tach_count, output ready);
endinterface

interface ftar_rsp_if import ftar_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SPEED_W-1:0] speed_rpm;
   logic [EXP_W-1:0]   new_exponent;
   logic               exponent_changed;
   logic               zero_count;

   modport source (output valid, output speed_rpm, output new_exponent,
                   output exponent_changed, output zero_count, input ready);
   modport sink   (input valid, input speed_rpm, input new_exponent,
                   input exponent_changed, input zero_count, output ready);
endinterface

FILE: rtl/core/fan_tach_autorange_rpm_top.sv
// Top level of the fan tachometer speed block with divisor auto-ranging.
// Depends on ftar_pkg, ftar_if, ftar_ctrl and ftar_datapath.
`timescale 1ns / 1ps

// Each request transaction carries a fan number and its 8-bit tachometer
// count and produces one response: speed in RPM as 1350000 / (count << exp)
// using the fan's exponent before the update (0 for a stall count of 255,
// 1350000 for a zero count), the auto-ranged exponent, a changed flag and a
// zero-count flag. From acceptance to the output register a transaction goes
// through: accept and update the exponent, load the divider, 21 iterations of
// the one-bit-per-cycle restoring divider, and publish. A new request is
// accepted as soon as the previous result has moved to the output register,
// even while that result still waits to be taken. Thresholds may be written
// through the csr port only while no transaction is in flight.
module fan_tach_autorange_rpm_top import ftar_pkg::*; #(
   parameter int NUM_FANS = NUM_FANS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   ftar_req_if.sink               req_chan,
   ftar_rsp_if.source             rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [THR_W-1:0]       csr_write_data
);

   ftar_cmd_type    cmd;
   ftar_status_type status;
   logic            req_ready;

   // Sequencer
   ftar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   assign req_chan.ready = req_ready;

   // Datapath
   ftar_datapath #(
      .NUM_FANS (NUM_FANS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_valid      (req_chan.valid),
      .req_fan_index  (req_chan.fan_index),
      .req_tach_count (req_chan.tach_count),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .rsp            (rsp_chan)
   );

endmodule

FILE: rtl/core/ftar_ctrl.sv
// Sequencer for the fan tachometer block: accept, divider load, iterate, publish.
// Depends on ftar_pkg for the command and status structs.
`timescale 1ns / 1ps

module ftar_ctrl import ftar_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  ftar_status_type status,
   output ftar_cmd_type    cmd,
   output logic            req_ready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIVIDE,
      ST_PUBLISH
   } state_type;

   state_type state_ff, state_in;

   // Decode commands from the current state
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = status.req_valid;
            if (status.req_valid) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.init = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (status.step_last) state_in = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            // hold until the output register can take the result
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/ftar_datapath.sv
// Datapath: threshold registers, per-fan exponent store, restoring divider and
// output register. Depends on ftar_pkg and the response interface in ftar_if.
`timescale 1ns / 1ps

module ftar_datapath import ftar_pkg::*; #(
   parameter int NUM_FANS = NUM_FANS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ftar_cmd_type           cmd,
   output ftar_status_type        status,
   input  logic                   req_valid,
   input  logic [FAN_W-1:0]       req_fan_index,
   input  logic [COUNT_W-1:0]     req_tach_count,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [THR_W-1:0]       csr_write_data,
   ftar_rsp_if.source             rsp
);

   localparam int FAN_IDX_W = (NUM_FANS > 1) ? $clog2(NUM_FANS) : 1;

   logic [THR_W-1:0] upper_ff, lower_ff;

   logic [EXP_W-1:0] exp_ff [NUM_FANS];

   logic [COUNT_W-1:0] count_ff;
   logic [EXP_W-1:0]   old_exp_ff, new_exp_ff;
   logic               changed_ff;

   logic [DIV_W-1:0]  divisor_ff;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff;

   logic               rsp_valid_ff;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic [EXP_W-1:0]   rsp_exp_ff;
   logic               rsp_changed_ff, rsp_zero_ff;

   logic                 fan_valid;
   logic [FAN_IDX_W-1:0] fan_idx;
   logic [EXP_W-1:0]     cur_exp, next_exp;
   logic [REM_W-1:0]     trial, diff;
   logic                 is_zero, is_stall;

   // Look up and auto-range the exponent of the requested fan
   always_comb begin
      fan_valid = (32'(req_fan_index) < NUM_FANS);
      fan_idx   = FAN_IDX_W'(req_fan_index);
      cur_exp   = fan_valid ? exp_ff[fan_idx] : '0;
      next_exp  = cur_exp;
      if (fan_valid) begin
         if (req_tach_count > upper_ff && cur_exp < MAX_EXPONENT) begin
            next_exp = cur_exp + 1'b1;
         end else if (req_tach_count < lower_ff && cur_exp != '0) begin
            next_exp = cur_exp - 1'b1;
         end
      end
   end

   // One restoring division step
   always_comb begin
      trial  = {rem_ff[REM_W-2:0], quo_ff[QUO_W-1]};
      diff   = trial - {1'b0, divisor_ff};
      if (trial >= {1'b0, divisor_ff}) begin
         rem_in = diff;
         quo_in = {quo_ff[QUO_W-2:0], 1'b1};
      end else begin
         rem_in = trial;
         quo_in = {quo_ff[QUO_W-2:0], 1'b0};
      end
   end

   // Override the quotient for stalled and zero counts
   always_comb begin
      is_zero  = (count_ff == '0);
      is_stall = (count_ff == STALL_COUNT);
      if (is_stall)      speed_in = '0;
      else if (is_zero)  speed_in = RPM_NUMERATOR;
      else               speed_in = quo_ff;
   end

   // Threshold registers and the exponent store
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= UPPER_THRESHOLD_RESET;
         lower_ff <= LOWER_THRESHOLD_RESET;
         for (int i = 0; i < NUM_FANS; i++) exp_ff[i] <= '0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_UPPER_THRESHOLD: upper_ff <= csr_write_data;
               CSR_LOWER_THRESHOLD: lower_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (cmd.accept && fan_valid) exp_ff[fan_idx] <= next_exp;
      end
   end

   // Capture the transaction, run the divider
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         count_ff   <= req_tach_count;
         old_exp_ff <= cur_exp;
         new_exp_ff <= next_exp;
         changed_ff <= (next_exp != cur_exp);
      end
      if (cmd.init) begin
         divisor_ff <= DIV_W'(count_ff) << old_exp_ff;
         rem_ff     <= '0;
         quo_ff     <= RPM_NUMERATOR;
         step_ff    <= '0;
      end else if (cmd.step) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         step_ff <= step_ff + 1'b1;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         speed_ff       <= speed_in;
         rsp_exp_ff     <= new_exp_ff;
         rsp_changed_ff <= changed_ff;
         rsp_zero_ff    <= is_zero;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.speed_rpm        = speed_ff;
   assign rsp.new_exponent     = rsp_exp_ff;
   assign rsp.exponent_changed = rsp_changed_ff;
   assign rsp.zero_count       = rsp_zero_ff;

   assign status.req_valid = req_valid;
   assign status.step_last = (step_ff == STEP_W'(QUO_W - 1));
   assign status.out_free  = !rsp_valid_ff || rsp.ready;

   // A publish never overwrites a result still waiting
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp.ready))
      else $error("result published over a pending transaction");

   // The divider never runs past the last quotient bit
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (step_ff <= STEP_W'(QUO_W - 1)))
      else $error("divider stepped past the last quotient bit");

   // A finished division leaves a remainder below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.publish && !is_zero) |-> (rem_ff < {1'b0, divisor_ff}))
      else $error("divider remainder not below divisor");

   // A zero count always reports the saturated speed
   a_zero_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_zero_ff) |-> (speed_ff == RPM_NUMERATOR))
      else $error("zero count without saturated speed");

endmodule

FILE: tb/tb_fan_tach_autorange_rpm_top.sv
// Self-checking testbench for fan_tach_autorange_rpm_top: RPM and divisor auto-ranging.
// Depends on ftar_pkg, ftar_if and the RTL top; a small scoreboard class predicts each response.
`timescale 1ns / 1ps

import ftar_pkg::*;

typedef struct packed {
   logic [SPEED_W-1:0] speed_rpm;
   logic [EXP_W-1:0]   new_exponent;
   logic               exponent_changed;
   logic               zero_count;
} rpm_reading_t;

// Tracks the per-fan divisor exponents and the queue of expected readings
class rpm_scoreboard;
   logic [EXP_W-1:0] fan_exponent [NUM_FANS_DEFAULT];
   logic [THR_W-1:0] upper_thr;
   logic [THR_W-1:0] lower_thr;
   rpm_reading_t     reading_q [$];
   int               errors;
   int               checked;
   int               zero_seen;
   int               stall_seen;
   int               changes_seen;

   function void clear_state();
      foreach (fan_exponent[i]) fan_exponent[i] = '0;
      upper_thr    = UPPER_THRESHOLD_RESET;
      lower_thr    = LOWER_THRESHOLD_RESET;
      errors       = 0;
      checked      = 0;
      zero_seen    = 0;
      stall_seen   = 0;
      changes_seen = 0;
   endfunction

   function void set_thresholds(input logic [THR_W-1:0] upr, input logic [THR_W-1:0] lwr);
      upper_thr = upr;
      lower_thr = lwr;
   endfunction

   // Predict the reading for one accepted request and advance the fan's exponent
   function void note_request(input logic [FAN_W-1:0] fan, input logic [COUNT_W-1:0] count);
      rpm_reading_t     want;
      logic [EXP_W-1:0] old_exp;
      logic [EXP_W-1:0] next_exp;
      int unsigned      period;
      bit               known_fan;

      known_fan = (int'(fan) < NUM_FANS_DEFAULT);
      old_exp   = known_fan ? fan_exponent[fan] : '0;
      next_exp  = old_exp;

      if (count == STALL_COUNT) begin
         want.speed_rpm = '0;
         stall_seen++;
      end else if (count == '0) begin
         want.speed_rpm = RPM_NUMERATOR;
         zero_seen++;
      end else begin
         period = int'(count) << old_exp;
         want.speed_rpm = SPEED_W'(int'(RPM_NUMERATOR) / period);
      end

      if (known_fan) begin
         if (count > upper_thr && old_exp < MAX_EXPONENT) begin
            next_exp = old_exp + 1'b1;
         end else if (count < lower_thr && old_exp > 0) begin
            next_exp = old_exp - 1'b1;
         end
         fan_exponent[fan] = next_exp;
      end

      want.new_exponent     = next_exp;
      want.exponent_changed = known_fan && (next_exp != old_exp);
      want.zero_count       = (count == '0);
      if (want.exponent_changed) changes_seen++;
      reading_q.push_back(want);
   endfunction

   // Compare one response, field by field, with the oldest prediction
   function void check_reading(input rpm_reading_t got);
      rpm_reading_t want;

      if (reading_q.size() == 0) begin
         $error("unexpected response: speed_rpm=%0d new_exponent=%0d", got.speed_rpm,
                got.new_exponent);
         errors++;
         return;
      end
      want = reading_q.pop_front();
      checked++;
      if (got.speed_rpm !== want.speed_rpm) begin
         $error("speed_rpm: expected %0d, got %0d", want.speed_rpm, got.speed_rpm);
         errors++;
      end
      if (got.new_exponent !== want.new_exponent) begin
         $error("new_exponent: expected %0d, got %0d", want.new_exponent, got.new_exponent);
         errors++;
      end
      if (got.exponent_changed !== want.exponent_changed) begin
         $error("exponent_changed: expected %0b, got %0b", want.exponent_changed,
                got.exponent_changed);
         errors++;
      end
      if (got.zero_count !== want.zero_count) begin
         $error("zero_count: expected %0b, got %0b", want.zero_count, got.zero_count);
         errors++;
      end
   endfunction

   function int pending();
      return reading_q.size();
   endfunction
endclass

module tb_fan_tach_autorange_rpm_top;

   localparam int IDLE_PCT       = 7;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_ITEMS    = 100;
   localparam int NUM_PHASES     = 5;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [THR_W-1:0]       csr_write_data;

   ftar_req_if req_bus ();
   ftar_rsp_if rsp_bus ();

   rpm_scoreboard sb;

   bit no_idle      = 1'b0;
   bit hold_off_req = 1'b0;
   int idle_cycles  = 0;
   int settings_run = 0;

   logic [THR_W-1:0] upper_sel;
   logic [THR_W-1:0] lower_sel;

   fan_tach_autorange_rpm_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Offer one request transaction, with a random gap first, and hold it until taken
   task automatic send_request(input logic [FAN_W-1:0] fan, input logic [COUNT_W-1:0] count);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.fan_index  <= fan;
      req_bus.tach_count <= count;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop the request, wait for every predicted response, then let the block settle
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write both thresholds on consecutive cycles
   task automatic write_thresholds(input logic [THR_W-1:0] upr, input logic [THR_W-1:0] lwr);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_UPPER_THRESHOLD;
      csr_write_data <= upr;
      @(posedge clock);
      csr_index      <= CSR_LOWER_THRESHOLD;
      csr_write_data <= lwr;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      sb.set_thresholds(upr, lwr);
      settings_run++;
   endtask

   // Bias counts toward the thresholds and the stall and zero corners
   function automatic logic [COUNT_W-1:0] pick_count(input logic [THR_W-1:0] upr,
                                                      input logic [THR_W-1:0] lwr);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd254;
            3:       return STALL_COUNT;
            4:       return upr;
            5:       return upr + 8'd1;
            6:       return lwr;
            default: return lwr - 8'd1;
         endcase
      end else if (roll < 40) begin
         return COUNT_W'($urandom_range(int'(upr), 255));
      end else if (roll < 65) begin
         return COUNT_W'($urandom_range(0, int'(lwr)));
      end
      return COUNT_W'($urandom_range(0, 255));
   endfunction

   // Response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end
         rsp_bus.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Observe both channels; end the run if nothing moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            sb.note_request(req_bus.fan_index, req_bus.tach_count);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_reading('{rsp_bus.speed_rpm, rsp_bus.new_exponent,
                               rsp_bus.exponent_changed, rsp_bus.zero_count});
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      logic [FAN_W-1:0] fan;
      int               p;
      int               i;

      sb = new;
      sb.clear_state();
      req_bus.valid      <= 1'b0;
      req_bus.fan_index  <= '0;
      req_bus.tach_count <= '0;
      csr_write_en       <= 1'b0;
      csr_index          <= CSR_UPPER_THRESHOLD;
      csr_write_data     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero and stalled counts, thresholds edges, exponent walk up to 7, then down and up a step
      send_request(3'd0, 8'd0);
      send_request(3'd0, STALL_COUNT);
      send_request(3'd0, 8'd1);
      send_request(3'd0, 8'd96);
      send_request(3'd0, 8'd95);
      send_request(3'd0, 8'd192);
      send_request(3'd0, 8'd193);
      send_request(3'd0, 8'd0);
      repeat (8) send_request(3'd7, STALL_COUNT);
      send_request(3'd7, 8'd1);
      send_request(3'd7, 8'd254);
      send_request(3'd7, 8'd50);
      send_request(3'd3, 8'd128);

      // Random phases, each under its own threshold setting
      fan = '0;
      for (p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         case (p)
            0: begin upper_sel = UPPER_THRESHOLD_RESET; lower_sel = LOWER_THRESHOLD_RESET; end
            1: begin upper_sel = 8'd255; lower_sel = 8'd0;   end
            2: begin upper_sel = 8'd0;   lower_sel = 8'd255; end
            3: begin upper_sel = 8'd160; lower_sel = 8'd40;  end
            default: begin
               upper_sel = THR_W'($urandom_range(0, 255));
               lower_sel = THR_W'($urandom_range(0, 255));
            end
         endcase
         write_thresholds(upper_sel, lower_sel);
         no_idle = (p == 3);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 1 && i == 20) hold_off_req = 1'b1;
            // Stay on one fan for a while so its exponent can walk
            if ($urandom_range(0, 99) < 30) fan = FAN_W'($urandom_range(0, 7));
            send_request(fan, pick_count(upper_sel, lower_sel));
         end
         no_idle = 1'b0;
      end

      // Drain and report
      wait_drained();
      repeat (30) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d predicted responses never arrived", sb.pending());
         sb.errors++;
      end
      $display("Run checked %0d readings across %0d threshold settings plus reset values,",
               sb.checked, settings_run);
      $display("with %0d zero counts, %0d stalled fans, %0d exponent changes, one long stall.",
               sb.zero_seen, sb.stall_seen, sb.changes_seen);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: fan_tach_autorange_rpm_top.f
rtl/core/ftar_pkg.sv
rtl/core/ftar_if.sv
rtl/core/ftar_ctrl.sv
rtl/core/ftar_datapath.sv
rtl/core/fan_tach_autorange_rpm_top.sv
tb/tb_fan_tach_autorange_rpm_top.sv
